FILE: design/sbr_pkg.sv
`default_nettype none

package sbr_pkg;

   localparam logic [7:0] AckCode = 8'h06;
   localparam logic [7:0] NakCode = 8'h15;

   // Number of bytes returned for the name query.
   localparam int NameBytes = 16;

   // Width of the index into a reply sequence (the longest reply is 33 items).
   localparam int SeqIdxBits = 6;

   typedef enum logic [1:0] {
      TGT_UART = 2'd0,
      TGT_SPI  = 2'd1,
      TGT_CS   = 2'd2
   } target_type;

   typedef enum logic [7:0] {
      CMD_NOP      = 8'h00,
      CMD_IFACE    = 8'h01,
      CMD_CMDMAP   = 8'h02,
      CMD_NAME     = 8'h03,
      CMD_BUFSIZE  = 8'h04,
      CMD_BUSTYPE  = 8'h05,
      CMD_SYNCNOP  = 8'h10,
      CMD_SPI_OP   = 8'h13
   } command_type;

   // Each accepted item maps onto one of these fixed reply sequences.
   typedef enum logic [3:0] {
      RPL_NONE       = 4'd0,
      RPL_ACK        = 4'd1,
      RPL_IFACE      = 4'd2,
      RPL_CMDMAP     = 4'd3,
      RPL_NAME       = 4'd4,
      RPL_BUFSIZE    = 4'd5,
      RPL_BUSTYPE    = 4'd6,
      RPL_SYNC       = 4'd7,
      RPL_CS_SEL     = 4'd8,
      RPL_CS_ACK_RD  = 4'd9,
      RPL_CS_ACK_REL = 4'd10,
      RPL_SPI_BYTE   = 4'd11,
      RPL_ACK_RD     = 4'd12,
      RPL_ACK_REL    = 4'd13,
      RPL_UART_RD    = 4'd14,
      RPL_UART_REL   = 4'd15
   } reply_type;

   typedef struct packed {
      reply_type  kind;
      logic [7:0] data;
   } desc_type;

   typedef struct packed {
      target_type target;
      logic [7:0] out_byte;
   } result_type;

   function automatic logic [5:0] reply_count(input reply_type kind);
      logic [5:0] n;
      n = 6'd0;
      unique case (kind)
         RPL_NONE:       n = 6'd0;
         RPL_ACK:        n = 6'd1;
         RPL_IFACE:      n = 6'd3;
         RPL_CMDMAP:     n = 6'd33;
         RPL_NAME:       n = 6'(NameBytes + 1);
         RPL_BUFSIZE:    n = 6'd3;
         RPL_BUSTYPE:    n = 6'd2;
         RPL_SYNC:       n = 6'd2;
         RPL_CS_SEL:     n = 6'd1;
         RPL_CS_ACK_RD:  n = 6'd3;
         RPL_CS_ACK_REL: n = 6'd3;
         RPL_SPI_BYTE:   n = 6'd1;
         RPL_ACK_RD:     n = 6'd2;
         RPL_ACK_REL:    n = 6'd2;
         RPL_UART_RD:    n = 6'd2;
         RPL_UART_REL:   n = 6'd2;
         default:        n = 6'd0;
      endcase
      return n;
   endfunction

   // Programmer name; positions past its end read as zero.
   function automatic logic [7:0] name_byte(input logic [4:0] pos);
      logic [7:0] b;
      b = 8'h00;
      case (pos)
         5'd0:    b = 8'h73;
         5'd1:    b = 8'h65;
         5'd2:    b = 8'h72;
         5'd3:    b = 8'h70;
         5'd4:    b = 8'h72;
         5'd5:    b = 8'h6F;
         5'd6:    b = 8'h67;
         5'd7:    b = 8'h2D;
         5'd8:    b = 8'h64;
         5'd9:    b = 8'h75;
         5'd10:   b = 8'h69;
         5'd11:   b = 8'h6E;
         5'd12:   b = 8'h6F;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

   function automatic result_type reply_item(input reply_type kind,
                                             input logic [SeqIdxBits-1:0] idx,
                                             input logic [7:0] data);
      result_type r;
      r.target   = TGT_UART;
      r.out_byte = 8'h00;
      unique case (kind)
         RPL_ACK: begin
            r.out_byte = AckCode;
         end
         RPL_IFACE: begin
            r.out_byte = (idx == 6'd0) ? AckCode : ((idx == 6'd1) ? 8'h01 : 8'h00);
         end
         RPL_CMDMAP: begin
            case (idx)
               6'd0:    r.out_byte = AckCode;
               6'd1:    r.out_byte = 8'h3F;
               6'd3:    r.out_byte = 8'h09;
               default: r.out_byte = 8'h00;
            endcase
         end
         RPL_NAME: begin
            r.out_byte = (idx == 6'd0) ? AckCode : name_byte(5'(idx - 6'd1));
         end
         RPL_BUFSIZE: begin
            r.out_byte = (idx == 6'd0) ? AckCode : 8'h00;
         end
         RPL_BUSTYPE: begin
            r.out_byte = (idx == 6'd0) ? AckCode : 8'h08;
         end
         RPL_SYNC: begin
            r.out_byte = (idx == 6'd0) ? NakCode : AckCode;
         end
         RPL_CS_SEL: begin
            r.target   = TGT_CS;
            r.out_byte = 8'h01;
         end
         RPL_CS_ACK_RD, RPL_CS_ACK_REL: begin
            if (idx == 6'd0) begin
               r.target   = TGT_CS;
               r.out_byte = 8'h01;
            end else if (idx == 6'd1) begin
               r.out_byte = AckCode;
            end else begin
               r.target = (kind == RPL_CS_ACK_RD) ? TGT_SPI : TGT_CS;
            end
         end
         RPL_SPI_BYTE: begin
            r.target   = TGT_SPI;
            r.out_byte = data;
         end
         RPL_ACK_RD, RPL_ACK_REL: begin
            if (idx == 6'd0) begin
               r.out_byte = AckCode;
            end else begin
               r.target = (kind == RPL_ACK_RD) ? TGT_SPI : TGT_CS;
            end
         end
         RPL_UART_RD, RPL_UART_REL: begin
            if (idx == 6'd0) begin
               r.out_byte = data;
            end else begin
               r.target = (kind == RPL_UART_RD) ? TGT_SPI : TGT_CS;
            end
         end
         default: begin
            r.out_byte = 8'h00;
         end
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

FILE: design/serial_to_spi_flash_command_bridge.sv
`default_nettype none

// Channel   Dir  Handshake              Payload
// req       in   req_tvalid/req_tready  tdata[7:0] data_byte, tuser operation
// rsp       out  rsp_tvalid/rsp_tready  tdata[7:0] out_byte, tuser target, tlast last
//
// An item that causes results occupies the result sequencer until its last result
// is loaded (an item with none never occupies it), so the block takes one item per
// cycle while each causes at most one result and rsp is not stalled; the command
// map reply holds it for its 33 results. The first result passes the sequencer and
// the output register before it is valid on rsp. Reset is synchronous; it returns
// the command phase to idle and drops both sequencer and output valid. A stalled
// rsp holds its result while the next result waits in the sequencer.
module serial_to_spi_flash_command_bridge #(
   parameter int LENGTH_BITS = 24
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] data_byte
   input  wire logic        req_tuser,   // [0] operation
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,   // [7:0] out_byte
   output logic [1:0]       rsp_tuser,   // [1:0] target
   output logic             rsp_tlast
);

   sbr_pkg::desc_type    desc;
   sbr_pkg::result_type  result;
   logic                 take;

   assign take = req_tvalid && req_tready;

   sbr_engine #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .take      (take),
      .from_spi  (req_tuser),
      .data_byte (req_tdata),
      .desc      (desc)
   );

   sbr_emitter u_emitter (
      .clock      (clock),
      .reset      (reset),
      .desc_valid (req_tvalid),
      .desc       (desc),
      .desc_ready (req_tready),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_result (result),
      .out_last   (rsp_tlast)
   );

   assign rsp_tdata = result.out_byte;
   assign rsp_tuser = result.target;

   // A chip-select result only ever selects or releases.
   a_cs_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == sbr_pkg::TGT_CS |-> rsp_tdata[7:1] == 7'd0)
      else $error("chip-select result carries a byte other than 0 or 1");

   // Results of one item leave without gaps once the previous one is taken.
   a_no_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=> rsp_tvalid)
      else $error("gap inside the results of one item");

   // No new item enters while a stalled result is not its item's last.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready && !rsp_tlast |-> !req_tready)
      else $error("item accepted while an earlier item still has results");

endmodule

`default_nettype wire

FILE: design/sbr_engine.sv
`default_nettype none

module sbr_engine #(
   parameter int LENGTH_BITS = 24
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             take,
   input  wire logic             from_spi,
   input  wire logic [7:0]       data_byte,
   output sbr_pkg::desc_type     desc
);

   localparam int LenBytes = (LENGTH_BITS + 7) / 8;
   localparam int LenIdxBits = (LenBytes > 1) ? $clog2(LenBytes) : 1;

   typedef enum logic [5:0] {
      PH_IDLE    = 6'b000001,
      PH_SLEN    = 6'b000010,
      PH_RLEN    = 6'b000100,
      PH_WR_HOST = 6'b001000,
      PH_WR_WAIT = 6'b010000,
      PH_RD_WAIT = 6'b100000
   } phase_type;

   phase_type               phase_ff, phase_in;
   logic [LenIdxBits-1:0]   len_idx_ff, len_idx_in;
   logic [LENGTH_BITS-1:0]  wr_rem_ff, wr_rem_in;
   logic [LENGTH_BITS-1:0]  rd_rem_ff, rd_rem_in;

   logic [LENGTH_BITS+7:0]  part_wide;
   logic [LENGTH_BITS-1:0]  part;
   logic [LENGTH_BITS-1:0]  wr_dec;
   logic [LENGTH_BITS-1:0]  rd_dec;
   logic [LENGTH_BITS-1:0]  rd_new;
   logic                    len_done;

   assign part_wide = (LENGTH_BITS + 8)'(data_byte) << {len_idx_ff, 3'b000};
   assign part      = part_wide[LENGTH_BITS-1:0];
   assign wr_dec    = wr_rem_ff - LENGTH_BITS'(1);
   assign rd_dec    = rd_rem_ff - LENGTH_BITS'(1);
   assign rd_new    = rd_rem_ff | part;
   assign len_done  = (len_idx_ff == LenIdxBits'(LenBytes - 1));

   always_comb begin
      phase_in   = phase_ff;
      len_idx_in = len_idx_ff;
      wr_rem_in  = wr_rem_ff;
      rd_rem_in  = rd_rem_ff;
      desc.kind  = sbr_pkg::RPL_NONE;
      desc.data  = data_byte;
      unique case (phase_ff)
         PH_IDLE: begin
            if (!from_spi) begin
               unique case (data_byte)
                  sbr_pkg::CMD_NOP:     desc.kind = sbr_pkg::RPL_ACK;
                  sbr_pkg::CMD_IFACE:   desc.kind = sbr_pkg::RPL_IFACE;
                  sbr_pkg::CMD_CMDMAP:  desc.kind = sbr_pkg::RPL_CMDMAP;
                  sbr_pkg::CMD_NAME:    desc.kind = sbr_pkg::RPL_NAME;
                  sbr_pkg::CMD_BUFSIZE: desc.kind = sbr_pkg::RPL_BUFSIZE;
                  sbr_pkg::CMD_BUSTYPE: desc.kind = sbr_pkg::RPL_BUSTYPE;
                  sbr_pkg::CMD_SYNCNOP: desc.kind = sbr_pkg::RPL_SYNC;
                  sbr_pkg::CMD_SPI_OP: begin
                     wr_rem_in  = '0;
                     rd_rem_in  = '0;
                     len_idx_in = '0;
                     phase_in   = PH_SLEN;
                  end
                  default: desc.kind = sbr_pkg::RPL_NONE;
               endcase
            end
         end
         PH_SLEN: begin
            if (!from_spi) begin
               wr_rem_in  = wr_rem_ff | part;
               len_idx_in = len_done ? '0 : len_idx_ff + LenIdxBits'(1);
               if (len_done) begin
                  phase_in = PH_RLEN;
               end
            end
         end
         PH_RLEN: begin
            if (!from_spi) begin
               rd_rem_in  = rd_new;
               len_idx_in = len_done ? '0 : len_idx_ff + LenIdxBits'(1);
               if (len_done) begin
                  if (wr_rem_ff != '0) begin
                     desc.kind = sbr_pkg::RPL_CS_SEL;
                     phase_in  = PH_WR_HOST;
                  end else if (rd_new != '0) begin
                     desc.kind = sbr_pkg::RPL_CS_ACK_RD;
                     phase_in  = PH_RD_WAIT;
                  end else begin
                     desc.kind = sbr_pkg::RPL_CS_ACK_REL;
                     phase_in  = PH_IDLE;
                  end
               end
            end
         end
         PH_WR_HOST: begin
            if (!from_spi) begin
               desc.kind = sbr_pkg::RPL_SPI_BYTE;
               phase_in  = PH_WR_WAIT;
            end
         end
         PH_WR_WAIT: begin
            if (from_spi) begin
               wr_rem_in = wr_dec;
               if (wr_dec != '0) begin
                  phase_in = PH_WR_HOST;
               end else if (rd_rem_ff != '0) begin
                  desc.kind = sbr_pkg::RPL_ACK_RD;
                  phase_in  = PH_RD_WAIT;
               end else begin
                  desc.kind = sbr_pkg::RPL_ACK_REL;
                  phase_in  = PH_IDLE;
               end
            end
         end
         PH_RD_WAIT: begin
            if (from_spi) begin
               rd_rem_in = rd_dec;
               if (rd_dec != '0) begin
                  desc.kind = sbr_pkg::RPL_UART_RD;
               end else begin
                  desc.kind = sbr_pkg::RPL_UART_REL;
                  phase_in  = PH_IDLE;
               end
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         len_idx_ff <= '0;
         wr_rem_ff  <= '0;
         rd_rem_ff  <= '0;
      end else if (take) begin
         phase_ff   <= phase_in;
         len_idx_ff <= len_idx_in;
         wr_rem_ff  <= wr_rem_in;
         rd_rem_ff  <= rd_rem_in;
      end
   end

endmodule

`default_nettype wire

FILE: design/sbr_emitter.sv
`default_nettype none

module sbr_emitter (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              desc_valid,
   input  wire sbr_pkg::desc_type desc,
   output logic                   desc_ready,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output sbr_pkg::result_type    out_result,
   output logic                   out_last
);

   logic                                seq_valid_ff;
   sbr_pkg::desc_type                   seq_ff;
   logic [sbr_pkg::SeqIdxBits-1:0]      idx_ff;
   logic                                out_valid_ff;
   sbr_pkg::result_type                 out_result_ff;
   logic                                out_last_ff;

   logic                                out_free;
   logic                                is_last;
   logic                                load;
   logic                                finish;
   logic                                take;

   assign out_free   = !out_valid_ff || out_ready;
   assign is_last    = (idx_ff == sbr_pkg::reply_count(seq_ff.kind) - 6'd1);
   assign load       = seq_valid_ff && out_free;
   assign finish     = load && is_last;
   assign desc_ready = !seq_valid_ff || finish;
   assign take       = desc_valid && desc_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (take) begin
            // An item that causes no result never occupies the sequencer.
            seq_valid_ff <= (desc.kind != sbr_pkg::RPL_NONE);
         end else if (finish) begin
            seq_valid_ff <= 1'b0;
         end
         if (load) begin
            out_valid_ff <= 1'b1;
         end else if (out_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         seq_ff <= desc;
         idx_ff <= '0;
      end else if (load) begin
         idx_ff <= idx_ff + 6'd1;
      end
      if (load) begin
         out_result_ff <= sbr_pkg::reply_item(seq_ff.kind, idx_ff, seq_ff.data);
         out_last_ff   <= is_last;
      end
   end

   assign out_valid  = out_valid_ff;
   assign out_result = out_result_ff;
   assign out_last   = out_last_ff;

endmodule

`default_nettype wire
